// ----- rtl/core/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// Used by the front, queue, back, checker and top-level modules; no dependencies.
package u8u16_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
   localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
   localparam logic [30:0] SUPP_FIRST     = 31'h0001_0000;
   localparam logic [30:0] SUPP_LAST      = 31'h0010_FFFF;
   localparam logic [30:0] ASCII_LAST     = 31'h0000_007F;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final;
   } req_beat_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        decode_error;
      logic        last_of_run;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      KIND_SINGLE = 2'd0,
      KIND_PAIR   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // payload: code unit in the low 16 bits, or the 20-bit supplementary offset
   typedef struct packed {
      kind_type    kind;
      logic [19:0] payload;
   } queue_entry_type;

   typedef struct packed {
      logic            push;
      queue_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic            valid;
      logic            full;
      queue_entry_type entry;
   } queue_head_type;

endpackage

// ----- rtl/core/u8u16_front.sv -----
// Front end: accepts UTF-8 bytes, tracks the open sequence and pushes a queue
// entry for each completed character or error. Depends on u8u16_pkg.
module u8u16_front
   import u8u16_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_stall,
   input  req_beat_type   req_beat,
   output queue_push_type push_out
);

   logic [30:0] acc_ff, acc_in;
   logic [2:0]  rem_ff, rem_in;
   logic        err_ff, err_in;

   logic [30:0] acc_shift;
   logic [30:0] supp_off;
   logic [2:0]  rem_dec;
   logic [7:0]  b;
   logic        fin;

   assign b         = req_beat.data_byte;
   assign fin       = req_beat.is_final;
   assign acc_shift = {acc_ff[24:0], b[5:0]};
   assign rem_dec   = rem_ff - 3'd1;
   assign supp_off  = acc_shift - SUPP_FIRST;

   always_comb begin
      logic raise;
      raise             = 1'b0;
      acc_in            = acc_ff;
      rem_in            = rem_ff;
      err_in            = err_ff;
      push_out.push     = 1'b0;
      push_out.entry.kind    = KIND_SINGLE;
      push_out.entry.payload = '0;

      if (req_valid && !req_stall && !err_ff) begin
         if (rem_ff != 3'd0) begin
            if (b[7:6] != 2'b10) begin
               raise = 1'b1;
            end else if (rem_dec != 3'd0) begin
               acc_in = acc_shift;
               rem_in = rem_dec;
               if (fin) begin
                  raise = 1'b1;
               end
            end else begin
               acc_in = '0;
               rem_in = '0;
               if (acc_shift <= ASCII_LAST) begin
                  raise = 1'b1;
               end else if (acc_shift >= SUPP_FIRST && acc_shift <= SUPP_LAST) begin
                  push_out.push          = 1'b1;
                  push_out.entry.kind    = KIND_PAIR;
                  push_out.entry.payload = supp_off[19:0];
               end else begin
                  push_out.push          = 1'b1;
                  push_out.entry.kind    = KIND_SINGLE;
                  push_out.entry.payload = {4'd0, acc_shift[15:0]};
               end
            end
         end else begin
            priority if (!b[7]) begin
               push_out.push          = 1'b1;
               push_out.entry.kind    = KIND_SINGLE;
               push_out.entry.payload = {12'd0, b};
            end else if (!b[6]) begin
               raise = 1'b1;
            end else if (b[7:1] == 7'b1111111) begin
               raise = 1'b1;
            end else begin
               // lead byte: keep the payload bits below the length prefix
               priority if (!b[5]) begin
                  acc_in = {26'd0, b[4:0]};
                  rem_in = 3'd1;
               end else if (!b[4]) begin
                  acc_in = {27'd0, b[3:0]};
                  rem_in = 3'd2;
               end else if (!b[3]) begin
                  acc_in = {28'd0, b[2:0]};
                  rem_in = 3'd3;
               end else if (!b[2]) begin
                  acc_in = {29'd0, b[1:0]};
                  rem_in = 3'd4;
               end else begin
                  acc_in = {30'd0, b[0]};
                  rem_in = 3'd5;
               end
               if (fin) begin
                  raise = 1'b1;
               end
            end
         end

         if (raise) begin
            err_in                 = 1'b1;
            acc_in                 = '0;
            rem_in                 = '0;
            push_out.push          = 1'b1;
            push_out.entry.kind    = KIND_ERROR;
            push_out.entry.payload = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         rem_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
         err_ff <= err_in;
      end
   end

endmodule

// ----- rtl/core/u8u16_queue.sv -----
// Short queue of classified entries between front and back ends.
// Depends on u8u16_pkg.
module u8u16_queue
   import u8u16_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_push_type push_in,
   input  logic           pop,
   output queue_head_type head
);

   queue_entry_type        store_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign head.valid = (count_ff != '0);
   assign head.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head.entry = store_ff[rd_ptr_ff];

   assign do_push = push_in.push && !head.full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

endmodule

// ----- rtl/core/u8u16_back.sv -----
// Back end: turns queue entries into UTF-16 result beats through an
// output register; a surrogate pair takes two beats. Depends on u8u16_pkg.
module u8u16_back
   import u8u16_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_beat_type   rsp_beat
);

   logic         valid_ff, valid_in;
   logic         pend_ff, pend_in;
   rsp_beat_type beat_ff, beat_in;
   logic         load;

   assign load      = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

   always_comb begin
      pop      = 1'b0;
      pend_in  = pend_ff;
      beat_in  = beat_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         if (pend_ff) begin
            // second half of a pair: retire the entry now
            beat_in.code_unit    = SURR_LOW_BASE | {6'd0, head.entry.payload[9:0]};
            beat_in.decode_error = 1'b0;
            beat_in.last_of_run  = 1'b1;
            valid_in             = 1'b1;
            pend_in              = 1'b0;
            pop                  = 1'b1;
         end else if (head.valid) begin
            valid_in = 1'b1;
            unique case (head.entry.kind)
               KIND_SINGLE: begin
                  beat_in.code_unit    = head.entry.payload[15:0];
                  beat_in.decode_error = 1'b0;
                  beat_in.last_of_run  = 1'b1;
                  pop                  = 1'b1;
               end
               KIND_PAIR: begin
                  beat_in.code_unit    = SURR_HIGH_BASE | {6'd0, head.entry.payload[19:10]};
                  beat_in.decode_error = 1'b0;
                  beat_in.last_of_run  = 1'b0;
                  pend_in              = 1'b1;
               end
               default: begin
                  beat_in.code_unit    = '0;
                  beat_in.decode_error = 1'b1;
                  beat_in.last_of_run  = 1'b1;
                  pop                  = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

endmodule

// ----- rtl/core/utf8_to_utf16_decoder.sv -----
// UTF-8 to UTF-16 decoder: front end, entry queue and back end.
// An accepted byte's entry passes through the queue and the output register.
// Throughput: one byte per cycle while the queue is not full; a surrogate pair
// takes two output beats, and the four-entry queue absorbs that and downstream stalls.
// Reset (synchronous) clears the sequence state, sticky error, queue and
// output valid; no clearing pass is needed.
module utf8_to_utf16_decoder
   import u8u16_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_beat,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_beat
);

   queue_push_type push_bus;
   queue_head_type head_bus;
   logic           pop;

   // hold input while the queue has no room for a possible entry
   assign req_stall = head_bus.full;

   u8u16_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .push_out  (push_bus)
   );

   u8u16_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push_bus),
      .pop     (pop),
      .head    (head_bus)
   );

   u8u16_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head_bus),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

endmodule

// ----- rtl/core/u8u16_checker.sv -----
// Port-level checks for the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends on u8u16_pkg.
module u8u16_checker
   import u8u16_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_beat_type rsp_beat
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
      else $error("result beat changed under stall");

   // nothing follows a delivered error beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_beat.decode_error |=> !rsp_valid)
      else $error("result after error");

   // error beats carry a zero unit and close the run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.decode_error |-> rsp_beat.code_unit == 16'd0 &&
      rsp_beat.last_of_run)
      else $error("malformed error beat");

   // only a high surrogate leaves a run open
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_beat.last_of_run |->
      rsp_beat.code_unit[15:10] == SURR_HIGH_BASE[15:10] && !rsp_beat.decode_error)
      else $error("open run without high surrogate");

   // a high surrogate is followed at once by its low half
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_beat.last_of_run |=>
      rsp_valid && rsp_beat.last_of_run &&
      rsp_beat.code_unit[15:10] == SURR_LOW_BASE[15:10])
      else $error("missing low surrogate");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_beat  (rsp_beat)
);
